// ===== rtl/smd_pkg.sv =====
// Shared types, command codes and SHA-1 constants for the message digest block.
`timescale 1ns / 1ps
`default_nettype none

package smd_pkg;

	localparam logic [1:0] SEL_IN   = 2'd0;
	localparam logic [1:0] SEL_MARK = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	localparam logic [1:0] GRP_CH  = 2'd0;
	localparam logic [1:0] GRP_PA1 = 2'd1;
	localparam logic [1:0] GRP_MAJ = 2'd2;
	localparam logic [1:0] GRP_PA2 = 2'd3;

	localparam logic [2:0] LAST_IDX = 3'd4;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       final_byte;
	} smd_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} smd_out_t;

	typedef struct packed {
		logic       push;
		logic [1:0] byte_sel;
		logic [2:0] len_idx;
		logic       wv_load;
		logic       round;
		logic [1:0] grp;
		logic       chain_add;
		logic       chain_init;
		logic       count_add;
		logic       count_clear;
		logic [2:0] out_idx;
	} smd_cmd_t;

	function automatic logic [31:0] h_init(input logic [2:0] idx);
		logic [31:0] h;
		unique case (idx)
			3'd0:    h = 32'h6745_2301;
			3'd1:    h = 32'hEFCD_AB89;
			3'd2:    h = 32'h98BA_DCFE;
			3'd3:    h = 32'h1032_5476;
			default: h = 32'hC3D2_E1F0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] round_k(input logic [1:0] grp);
		logic [31:0] k;
		unique case (grp)
			GRP_CH:  k = 32'h5A82_7999;
			GRP_PA1: k = 32'h6ED9_EBA1;
			GRP_MAJ: k = 32'h8F1B_BCDC;
			default: k = 32'hCA62_C1D6;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/smd_datapath.sv =====
// Datapath: block shift register, message schedule, round logic, chaining value, bit count.
`timescale 1ns / 1ps
`default_nettype none

module smd_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire smd_pkg::smd_cmd_t cmd,
	input  wire logic [7:0]       message_byte,
	output logic [31:0]           digest_word
);

	logic [511:0] blk_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  h_q [5];
	logic [63:0]  count_q;

	logic [7:0]   byte_in;
	logic [31:0]  w0, wx, w_new, f, tmp;

	always_comb begin
		case (cmd.byte_sel)
			smd_pkg::SEL_IN:   byte_in = message_byte;
			smd_pkg::SEL_MARK: byte_in = 8'h80;
			smd_pkg::SEL_ZERO: byte_in = 8'h00;
			default:           byte_in = count_q[{~cmd.len_idx, 3'b000} +: 8];
		endcase
	end

	assign w0    = blk_q[511:480];
	assign wx    = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w0;
	assign w_new = {wx[30:0], wx[31]};

	always_comb begin
		case (cmd.grp)
			smd_pkg::GRP_CH:  f = (b_q & c_q) | (~b_q & d_q);
			smd_pkg::GRP_MAJ: f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default:          f = b_q ^ c_q ^ d_q;
		endcase
	end

	assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + smd_pkg::round_k(cmd.grp) + w0;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wv_load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) h_q[i] <= smd_pkg::h_init(3'(i));
		end else if (cmd.chain_init) begin
			for (int i = 0; i < 5; i++) h_q[i] <= smd_pkg::h_init(3'(i));
		end else if (cmd.chain_add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_clear) begin
			count_q <= '0;
		end else if (cmd.count_add) begin
			count_q <= count_q + 64'd8;
		end
	end

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = h_q[0];
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			default: digest_word = h_q[4];
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/smd_ctrl.sv =====
// Controller: byte intake, padding sequencer, round counter and digest output sequencing.
`timescale 1ns / 1ps
`default_nettype none

module smd_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	input  wire logic        final_byte,
	output logic             byte_stall,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output smd_pkg::smd_cmd_t cmd,
	output logic [2:0]       word_index,
	output logic             last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [5:0] CNT_LAST = 6'd63;
	localparam logic [5:0] CNT_LEN  = 6'd56;
	localparam logic [6:0] RND_LAST = 7'd79;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [6:0] rnd_q;
	logic [1:0] ph_q;
	logic [2:0] li_q;
	logic [2:0] oi_q;
	logic       pad_q;
	logic       done_q;

	logic [1:0] pad_sel;
	logic [1:0] grp;

	always_comb begin
		if (ph_q == smd_pkg::SEL_MARK) begin
			pad_sel = smd_pkg::SEL_MARK;
		end else if (ph_q == smd_pkg::SEL_ZERO && cnt_q != CNT_LEN) begin
			pad_sel = smd_pkg::SEL_ZERO;
		end else begin
			pad_sel = smd_pkg::SEL_LEN;
		end
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			grp = smd_pkg::GRP_CH;
		end else if (rnd_q < 7'd40) begin
			grp = smd_pkg::GRP_PA1;
		end else if (rnd_q < 7'd60) begin
			grp = smd_pkg::GRP_MAJ;
		end else begin
			grp = smd_pkg::GRP_PA2;
		end
	end

	assign byte_stall   = (state_q != ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign word_index   = oi_q;
	assign last_word    = (oi_q == smd_pkg::LAST_IDX);

	always_comb begin
		cmd          = '0;
		cmd.len_idx  = li_q;
		cmd.grp      = grp;
		cmd.out_idx  = oi_q;
		cmd.byte_sel = smd_pkg::SEL_IN;
		unique case (state_q)
			ST_IDLE: begin
				cmd.push      = byte_valid;
				cmd.count_add = byte_valid;
				cmd.wv_load   = byte_valid && (cnt_q == CNT_LAST);
			end
			ST_PAD: begin
				cmd.push     = 1'b1;
				cmd.byte_sel = pad_sel;
				cmd.wv_load  = (cnt_q == CNT_LAST);
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
			end
			ST_ADD: begin
				cmd.chain_add = 1'b1;
			end
			ST_OUT: begin
				cmd.chain_init  = !digest_stall && (oi_q == smd_pkg::LAST_IDX);
				cmd.count_clear = !digest_stall && (oi_q == smd_pkg::LAST_IDX);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rnd_q   <= '0;
			ph_q    <= smd_pkg::SEL_MARK;
			li_q    <= '0;
			oi_q    <= '0;
			pad_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (byte_valid) begin
						cnt_q <= cnt_q + 6'd1;
						if (final_byte) begin
							pad_q <= 1'b1;
							ph_q  <= smd_pkg::SEL_MARK;
							li_q  <= '0;
						end
						if (cnt_q == CNT_LAST) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
						end else if (final_byte) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (pad_sel == smd_pkg::SEL_MARK) begin
						ph_q <= smd_pkg::SEL_ZERO;
					end else if (pad_sel == smd_pkg::SEL_LEN) begin
						ph_q <= smd_pkg::SEL_LEN;
						li_q <= li_q + 3'd1;
						if (li_q == 3'd7) begin
							done_q <= 1'b1;
						end
					end
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					if (rnd_q == RND_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_ADD: begin
					if (done_q) begin
						state_q <= ST_OUT;
						oi_q    <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						if (oi_q == smd_pkg::LAST_IDX) begin
							state_q <= ST_IDLE;
							oi_q    <= '0;
							cnt_q   <= '0;
							pad_q   <= 1'b0;
							done_q  <= 1'b0;
						end else begin
							oi_q <= oi_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sha1_message_digest.sv =====
// SHA-1 message digest: byte beats in, five 32-bit digest word beats out per message.
// Byte channel: byte_valid/byte_stall with byte_data (message_byte, final_byte).
// A beat is taken at a clock edge with valid high and stall low. Set final_byte
// on the last byte of the message; an empty message cannot be sent.
// Digest channel: digest_valid/digest_stall with digest_data (digest_word,
// word_index, last_word), most significant word first, last_word on the fifth.
// Bytes are taken one per cycle while a 64-byte block fills. The beat that
// completes a block stalls intake for the 80 rounds on the round unit and the
// chaining add that follows. After the final byte the padding sequencer
// inserts one byte per cycle (64 - n mod 64 bytes, plus 64 more when fewer than
// 9 remain in the block), each full block again stalling for rounds and add;
// the first digest word then appears and words follow one per cycle when not stalled.
// While the receiver stalls, the current digest word holds and no bytes are
// taken. After the fifth word the block re-initializes for the next message.
// Reset loads the SHA-1 initial chaining value and clears all counters.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire smd_pkg::smd_in_t  byte_data,
	output logic                   digest_valid,
	input  wire logic              digest_stall,
	output smd_pkg::smd_out_t      digest_data
);

	smd_pkg::smd_cmd_t cmd;
	logic [31:0]       digest_word;
	logic [2:0]        word_index;
	logic              last_word;

	smd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.final_byte   (byte_data.final_byte),
		.byte_stall   (byte_stall),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.cmd          (cmd),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	smd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_byte (byte_data.message_byte),
		.digest_word  (digest_word)
	);

	assign digest_data.digest_word = digest_word;
	assign digest_data.word_index  = word_index;
	assign digest_data.last_word   = last_word;

endmodule

`default_nettype wire
